// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the sorted-insert priority queue
// no dependencies; imported by spq_cell and the top level

package spq_pkg;

  // queue size and derived widths
  localparam int DEPTH = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int KEY_W = 16;
  localparam int TIME_W = 16;
  localparam int KIND_W = 3;
  localparam int OCC_W = 6;

  // stream widths
  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 48;

  // operation codes carried in tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // data carried with each key
  typedef struct packed {
    logic              is_start_event;
    logic [TIME_W-1:0] end_time;
    logic [KIND_W-1:0] package_kind;
    logic [KIND_W-1:0] test_kind;
  } payload_t;

  // one slot of the queue
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    payload_t         payload;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== hdl/sorted_insert_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// top level of the sorted-insert priority queue: chain of spq_cell slots,
// entry counter and registered result stage; uses spq_pkg and spq_cell

// The queue holds up to DEPTH entries in ascending key order in a row of
// cells; every cell compares its key with the incoming one in parallel and
// all cells shift together, so a push or a pop updates the row at once.
// An item is accepted in any cycle in which the result register is empty
// or its result is being taken, so sustained throughput is one item per
// clock; the result is registered and shown in the cycle after acceptance.
// A push with a key equal to the head's goes right behind the head; a push
// into a full queue is rejected with status full, a pop on an empty queue
// returns status empty with zero fields. Reset empties the queue at once.

module sorted_insert_priority_queue_unit import spq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // is_start_event, prio_key, end_time, package_kind, test_kind, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status, out_is_start_event, out_prio_key, out_end_time,
  // out_package_kind, out_test_kind, now_empty, occupancy
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic             accept;
  logic             is_push;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  cell_ctrl_t       ctrl;
  entry_t           new_entry;
  entry_t           cell_q     [DEPTH];
  logic             cell_stay  [DEPTH];
  entry_t           prev_entry [DEPTH];
  logic             prev_stay  [DEPTH];
  entry_t           next_entry [DEPTH];
  logic [DEPTH-1:0] valid_vec;

  // result register
  logic                  out_valid;
  status_t               res_status;
  entry_t                res_entry;
  logic [CNT_W-1:0]      res_count;
  status_t               status_next;
  entry_t                res_entry_next;

  // input handshake
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_push  = (s_tuser == OP_PUSH);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  // unpack the incoming item
  assign new_entry.valid                  = 1'b1;
  assign new_entry.payload.is_start_event = s_tdata[0];
  assign new_entry.key                    = s_tdata[16:1];
  assign new_entry.payload.end_time       = s_tdata[32:17];
  assign new_entry.payload.package_kind   = s_tdata[35:33];
  assign new_entry.payload.test_kind      = s_tdata[38:36];

  // command to the chain
  assign ctrl.push = accept && is_push && !full;
  assign ctrl.pop  = accept && (s_tuser == OP_POP) && !empty;

  // cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_entry[i] = '0;
      assign prev_stay[i]  = 1'b1;
    end else begin : g_inner
      assign prev_entry[i] = cell_q[i-1];
      assign prev_stay[i]  = cell_stay[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_entry[i] = '0;
    end else begin : g_mid
      assign next_entry[i] = cell_q[i+1];
    end
    assign valid_vec[i] = cell_q[i].valid;

    spq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .head_cell  (i == 0),
      .new_entry  (new_entry),
      .prev_entry (prev_entry[i]),
      .prev_stay  (prev_stay[i]),
      .next_entry (next_entry[i]),
      .entry      (cell_q[i]),
      .stay       (cell_stay[i])
    );
  end

  // entry counter
  always_comb begin
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result of the accepted item
  always_comb begin
    status_next    = ST_OK;
    res_entry_next = '0;
    if (is_push) begin
      if (full) begin
        status_next = ST_FULL;
      end
    end else if (empty) begin
      status_next = ST_EMPTY;
    end else begin
      res_entry_next = cell_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_status <= status_next;
      res_entry  <= res_entry_next;
      res_count  <= count_next;
    end
  end

  // pack the result
  assign m_tvalid = out_valid;
  assign m_tdata  = {OCC_W'(res_count),
                     (res_count == '0),
                     res_entry.payload.test_kind,
                     res_entry.payload.package_kind,
                     res_entry.payload.end_time,
                     res_entry.key,
                     res_entry.payload.is_start_event,
                     res_status};

  // checks on the chain and counter
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above queue depth");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell valid bits disagree with entry count");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    valid_vec[0] == (count != '0))
    else $error("head cell valid does not match queue emptiness");

  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    (accept && is_push && full) |=> (m_tvalid && (res_status == ST_FULL) && full))
    else $error("push into full queue not rejected");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.pop |=> (count == $past(count) - CNT_W'(1)))
    else $error("pop did not decrement entry count");

endmodule

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
// one slot of the sorted queue chain: holds an entry, compares it with
// the incoming key and shifts toward either neighbor; uses spq_pkg

module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       head_cell,   // tie goes behind this cell
  input  entry_t     new_entry,
  input  entry_t     prev_entry,
  input  logic       prev_stay,
  input  entry_t     next_entry,
  output entry_t     entry,
  output logic       stay
);

  logic             valid;
  logic [KEY_W-1:0] key;
  payload_t         payload;
  entry_t           entry_next;

  assign entry = '{valid: valid, key: key, payload: payload};

  // entry keeps its slot on a push when it sorts ahead of the new key
  assign stay = valid && ((key < new_entry.key) || (head_cell && (key == new_entry.key)));

  // choose what this slot holds after the command
  always_comb begin
    entry_next = entry;
    if (ctrl.push) begin
      if (!stay) begin
        entry_next = prev_stay ? new_entry : prev_entry;
      end
    end else if (ctrl.pop) begin
      entry_next = next_entry;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
  end

  // key and payload
  always_ff @(posedge clk) begin
    key     <= entry_next.key;
    payload <= entry_next.payload;
  end

endmodule
